[rtl/fcb_fmt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_fmt_pkg
// Shared types and constants for the 8.3 directory-name formatter.
// ----------------------------------------------------------------------------
package fcb_fmt_pkg;

  // Default field lengths
  localparam int BASE_LEN_DEF = 8;
  localparam int EXT_LEN_DEF  = 3;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  // Parsing phase
  typedef enum logic [4:0] {
    PH_BASE  = 5'b00001,  // filling the base part
    PH_SKIP  = 5'b00010,  // base full, dropping characters up to a dot
    PH_EXT   = 5'b00100,  // filling the extension
    PH_DONE  = 5'b01000,  // extension full, ignoring the rest
    PH_ENDED = 5'b10000   // NUL seen, ignoring the rest
  } phase_t;

  // Control state of the name being built
  typedef struct packed {
    phase_t     phase;
    logic [1:0] seen_len;   // characters seen, saturates at three
    logic [1:0] lead_dots;  // dots so far while the name is all dots
  } ctrl_t;

  localparam ctrl_t CTRL_RST = '{phase: PH_BASE, seen_len: 2'd0, lead_dots: 2'd0};

endpackage : fcb_fmt_pkg
`default_nettype wire

[rtl/fcb_fmt_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_fmt_core
// One-character state update and packing of the 11-character result.
// ----------------------------------------------------------------------------
module fcb_fmt_core
  import fcb_fmt_pkg::*;
#(
  parameter int BASE_LEN = BASE_LEN_DEF,
  parameter int EXT_LEN  = EXT_LEN_DEF,
  localparam int BCW = $clog2(BASE_LEN + 1),
  localparam int ECW = $clog2(EXT_LEN + 1)
) (
  input  wire logic [7:0]                ch,
  input  wire ctrl_t                     ctrl,
  input  wire logic [BASE_LEN-1:0][7:0]  base_chars,
  input  wire logic [BCW-1:0]            base_cnt,
  input  wire logic [EXT_LEN-1:0][7:0]   ext_chars,
  input  wire logic [ECW-1:0]            ext_cnt,
  output ctrl_t                          ctrl_nxt,
  output logic [BASE_LEN-1:0][7:0]       base_chars_nxt,
  output logic [BCW-1:0]                 base_cnt_nxt,
  output logic [EXT_LEN-1:0][7:0]        ext_chars_nxt,
  output logic [ECW-1:0]                 ext_cnt_nxt,
  output logic [63:0]                    base_field,
  output logic [23:0]                    ext_field
);

  logic [63:0] base_raw;
  logic [23:0] ext_raw;
  logic        dot1;
  logic        dot2;

  always_comb begin
    ctrl_nxt       = ctrl;
    base_chars_nxt = base_chars;
    base_cnt_nxt   = base_cnt;
    ext_chars_nxt  = ext_chars;
    ext_cnt_nxt    = ext_cnt;
    if (ctrl.phase != PH_ENDED) begin
      if (ch == CH_NUL) begin
        ctrl_nxt.phase = PH_ENDED;
      end else begin
        if (ch == CH_DOT && ctrl.lead_dots == ctrl.seen_len && ctrl.seen_len < 2'd2) begin
          ctrl_nxt.lead_dots = ctrl.lead_dots + 2'd1;
        end
        if (ctrl.seen_len != 2'd3) begin
          ctrl_nxt.seen_len = ctrl.seen_len + 2'd1;
        end
        unique case (ctrl.phase)
          PH_BASE: begin
            if (ch == CH_DOT) begin
              ctrl_nxt.phase = PH_EXT;
            end else if (ch == CH_STAR) begin
              for (int i = 0; i < BASE_LEN; i++) begin
                if (BCW'(i) >= base_cnt) base_chars_nxt[i] = CH_QUERY;
              end
              base_cnt_nxt   = BCW'(BASE_LEN);
              ctrl_nxt.phase = PH_SKIP;
            end else begin
              for (int i = 0; i < BASE_LEN; i++) begin
                if (BCW'(i) == base_cnt) base_chars_nxt[i] = ch;
              end
              base_cnt_nxt = base_cnt + 1'b1;
              if (base_cnt + 1'b1 >= BCW'(BASE_LEN)) ctrl_nxt.phase = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (ch == CH_DOT) ctrl_nxt.phase = PH_EXT;
          end
          PH_EXT: begin
            if (ch == CH_STAR) begin
              for (int i = 0; i < EXT_LEN; i++) begin
                if (ECW'(i) >= ext_cnt) ext_chars_nxt[i] = CH_QUERY;
              end
              ext_cnt_nxt    = ECW'(EXT_LEN);
              ctrl_nxt.phase = PH_DONE;
            end else begin
              for (int i = 0; i < EXT_LEN; i++) begin
                if (ECW'(i) == ext_cnt) ext_chars_nxt[i] = ch;
              end
              ext_cnt_nxt = ext_cnt + 1'b1;
              if (ext_cnt + 1'b1 >= ECW'(EXT_LEN)) ctrl_nxt.phase = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Pack the stored characters, first one in the top byte; unused slots blank.
  for (genvar g = 0; g < 8; g++) begin : g_base
    if (g < BASE_LEN) begin : g_used
      assign base_raw[63-8*g -: 8] = base_chars_nxt[g];
    end else begin : g_pad
      assign base_raw[63-8*g -: 8] = CH_SPACE;
    end
  end

  // Only the first three extension characters are shown.
  for (genvar g = 0; g < 3; g++) begin : g_ext
    if (g < EXT_LEN) begin : g_used
      assign ext_raw[23-8*g -: 8] = ext_chars_nxt[g];
    end else begin : g_pad
      assign ext_raw[23-8*g -: 8] = CH_SPACE;
    end
  end

  // "." and ".." map to fixed forms
  assign dot1 = (ctrl_nxt.seen_len == 2'd1) && (ctrl_nxt.lead_dots == 2'd1);
  assign dot2 = (ctrl_nxt.seen_len == 2'd2) && (ctrl_nxt.lead_dots == 2'd2);

  assign base_field = dot1 ? {CH_DOT, {7{CH_SPACE}}} :
                      dot2 ? {CH_DOT, CH_DOT, {6{CH_SPACE}}} : base_raw;
  assign ext_field  = (dot1 || dot2) ? {3{CH_SPACE}} : ext_raw;

endmodule : fcb_fmt_core
`default_nettype wire

[rtl/fcb_8_3_name_formatter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fcb_8_3_name_formatter
// Streams a file name in, one character per transaction, and returns the
// blank-padded 8.3 directory form after the character flagged with tlast.
// ----------------------------------------------------------------------------
// Usage: send the name one character per input transaction (tdata[7:0]) with
// in_tlast on its final character. One character is taken every clock cycle
// unless the input stalls. The result (base and extension, 11 bytes) is
// registered once the flagged character leaves the input register and stays
// until taken; the next name may start right away. Input stalls only when a
// flagged character waits in the input register while a previous result
// still sits untaken in the output register. A NUL character ends the name
// early; later characters up to tlast are dropped. "*" fills with "?"; "."
// and ".." give their fixed forms. Case is passed through unchanged.
// ----------------------------------------------------------------------------
module fcb_8_3_name_formatter
  import fcb_fmt_pkg::*;
#(
  parameter int BASE_LEN = BASE_LEN_DEF,  // 1..8
  parameter int EXT_LEN  = EXT_LEN_DEF    // 1..8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] name_char
  input  wire logic        in_tlast,    // last_char
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata    // [63:0] base_field, [87:64] ext_field
);

  localparam int BCW = $clog2(BASE_LEN + 1);
  localparam int ECW = $clog2(EXT_LEN + 1);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       s1_fire;

  // name state
  ctrl_t                     ctrl_r, ctrl_nxt;
  logic [BASE_LEN-1:0][7:0]  base_chars_r, base_chars_nxt;
  logic [BCW-1:0]            base_cnt_r, base_cnt_nxt;
  logic [EXT_LEN-1:0][7:0]   ext_chars_r, ext_chars_nxt;
  logic [ECW-1:0]            ext_cnt_r, ext_cnt_nxt;

  logic [63:0] base_field;
  logic [23:0] ext_field;

  // output register
  logic        out_valid_r;
  logic [87:0] out_data_r;

  // Non-final characters never need the output register.
  assign s1_adv    = !s1_last_r || !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  fcb_fmt_core #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) u_core (
    .ch             (s1_char_r),
    .ctrl           (ctrl_r),
    .base_chars     (base_chars_r),
    .base_cnt       (base_cnt_r),
    .ext_chars      (ext_chars_r),
    .ext_cnt        (ext_cnt_r),
    .ctrl_nxt       (ctrl_nxt),
    .base_chars_nxt (base_chars_nxt),
    .base_cnt_nxt   (base_cnt_nxt),
    .ext_chars_nxt  (ext_chars_nxt),
    .ext_cnt_nxt    (ext_cnt_nxt),
    .base_field     (base_field),
    .ext_field      (ext_field)
  );

  // Name state: a flagged character closes the name and starts an empty one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r       <= CTRL_RST;
      base_chars_r <= {BASE_LEN{CH_SPACE}};
      base_cnt_r   <= '0;
      ext_chars_r  <= {EXT_LEN{CH_SPACE}};
      ext_cnt_r    <= '0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        ctrl_r       <= CTRL_RST;
        base_chars_r <= {BASE_LEN{CH_SPACE}};
        base_cnt_r   <= '0;
        ext_chars_r  <= {EXT_LEN{CH_SPACE}};
        ext_cnt_r    <= '0;
      end else begin
        ctrl_r       <= ctrl_nxt;
        base_chars_r <= base_chars_nxt;
        base_cnt_r   <= base_cnt_nxt;
        ext_chars_r  <= ext_chars_nxt;
        ext_cnt_r    <= ext_cnt_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_data_r <= {ext_field, base_field};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A closed name always lands in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> out_valid_r)
    else $error("closed name did not produce a result");

  // After a closed name the state is empty again.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> base_cnt_r == '0 && ext_cnt_r == '0 &&
                             ctrl_r.phase == PH_BASE && ctrl_r.seen_len == 2'd0)
    else $error("name state not cleared after result");

  // Fill counts stay within their fields.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    base_cnt_r <= BCW'(BASE_LEN) && ext_cnt_r <= ECW'(EXT_LEN))
    else $error("fill count past field length");

  // Dot count never runs ahead of characters seen.
  a_dots_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.lead_dots <= ctrl_r.seen_len)
    else $error("leading dot count exceeds length");

endmodule : fcb_8_3_name_formatter
`default_nettype wire

[sim/tb_fcb_8_3_name_formatter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fcb_8_3_name_formatter
// Self-checking bench for the 8.3 directory-name formatter. File names are
// streamed in one character per transaction. A local predictor builds the
// blank-padded base and extension for each name closed by tlast, and every
// result transaction is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fcb_8_3_name_formatter;
  import fcb_fmt_pkg::*;

  localparam int BASE_LEN      = BASE_LEN_DEF;
  localparam int EXT_LEN       = EXT_LEN_DEF;
  localparam int CHAR_TARGET   = 875;   // directed part plus about 850 random chars
  localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES  = 8;     // margin after the last result is taken

  // One input transaction: a character and its end-of-name flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } name_char_t;

  // One result transaction as the predictor sees it
  typedef struct packed {
    logic [63:0] base;
    logic [23:0] ext;
  } fcb_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;

  name_char_t  name_chars_q[$];   // characters waiting for the driver
  fcb_entry_t  fcb_expected_q[$]; // predicted directory entries, oldest first
  int          chars_queued = 0;
  int          error_count = 0;
  int          idle_cycles = 0;

  // Sender and receiver pacing
  int          tx_gap = 0;
  int          tx_count = 0;
  bit          tx_burst = 1'b0;
  int          rx_hold = 0;
  int          rx_count = 0;
  bit          rx_burst = 1'b0;

  // Predictor state: the name currently being parsed
  logic [7:0]  base_buf[8];
  logic [7:0]  ext_buf[8];
  logic [3:0]  base_cnt;
  logic [3:0]  ext_cnt;
  phase_t      name_phase;
  logic [1:0]  chars_seen;   // saturates at three
  logic [1:0]  dot_run;      // leading dots while the name is all dots

  fcb_8_3_name_formatter #(
    .BASE_LEN (BASE_LEN),
    .EXT_LEN  (EXT_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] name_char
    .in_tlast   (in_tlast),    // last_char
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)    // [63:0] base_field, [87:64] ext_field
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic clear_name_state();
    for (int i = 0; i < 8; i++) begin
      base_buf[i] = CH_SPACE;
      ext_buf[i]  = CH_SPACE;
    end
    base_cnt   = '0;
    ext_cnt    = '0;
    name_phase = PH_BASE;
    chars_seen = '0;
    dot_run    = '0;
  endtask

  // Folds one character into the name being built
  task automatic absorb_char(input logic [7:0] c);
    if (name_phase == PH_ENDED)
      return;
    if (c == CH_NUL) begin
      name_phase = PH_ENDED;
      return;
    end
    // dot-name tracking: only counts while every char so far was a dot
    if (c == CH_DOT && dot_run == chars_seen && chars_seen < 2)
      dot_run++;
    if (chars_seen < 3)
      chars_seen++;

    case (name_phase)
      PH_BASE: begin
        if (c == CH_DOT) begin
          name_phase = PH_EXT;
        end else if (c == CH_STAR) begin
          while (base_cnt < BASE_LEN && base_cnt < 8) begin
            base_buf[base_cnt] = CH_QUERY;
            base_cnt++;
          end
          name_phase = PH_SKIP;
        end else begin
          if (base_cnt < 8)
            base_buf[base_cnt] = c;
          base_cnt++;
          if (base_cnt >= BASE_LEN)
            name_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (c == CH_DOT)
          name_phase = PH_EXT;
      end
      PH_EXT: begin
        // further dots land here as ordinary extension chars
        if (c == CH_STAR) begin
          while (ext_cnt < EXT_LEN && ext_cnt < 8) begin
            ext_buf[ext_cnt] = CH_QUERY;
            ext_cnt++;
          end
          name_phase = PH_DONE;
        end else begin
          if (ext_cnt < 8)
            ext_buf[ext_cnt] = c;
          ext_cnt++;
          if (ext_cnt >= EXT_LEN)
            name_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // Closes the name: "." and ".." get their fixed forms, then pack and clear
  task automatic close_name(output fcb_entry_t entry);
    if ((chars_seen == 2'd1 && dot_run == 2'd1) ||
        (chars_seen == 2'd2 && dot_run == 2'd2)) begin
      for (int i = 0; i < 8; i++) begin
        base_buf[i] = CH_SPACE;
        ext_buf[i]  = CH_SPACE;
      end
      base_buf[0] = CH_DOT;
      if (dot_run == 2'd2)
        base_buf[1] = CH_DOT;
    end
    for (int i = 0; i < 8; i++)
      entry.base[63 - 8*i -: 8] = base_buf[i];
    for (int i = 0; i < 3; i++)
      entry.ext[23 - 8*i -: 8] = ext_buf[i];
    clear_name_state();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_char(input logic [7:0] c, input logic last);
    name_chars_q.push_back('{ch: c, last: last});
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], i == s.len() - 1);
  endtask

  // Mostly short gaps, some medium, a few long; none at all in a burst stretch
  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Character for a well-formed name; stars show up now and then, dots only in the extension
  function automatic logic [7:0] pick_name_char(input bit in_ext);
    int r;
    r = $urandom_range(0, 99);
    if (r < 9)
      return CH_STAR;
    if (in_ext && r < 17)
      return CH_DOT;
    if (r < 70)
      return 8'("A" + $urandom_range(0, 25));
    if (r < 85)
      return 8'("0" + $urandom_range(0, 9));
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  task automatic queue_random_name();
    logic [7:0] chars[$];
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // runs of dots: ".", ".." and the non-special "..."
      repeat ($urandom_range(1, 3)) chars.push_back(CH_DOT);
    end else if (kind < 18) begin
      // raw byte noise, every bit pattern
      repeat ($urandom_range(1, 12)) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 10)) chars.push_back(pick_name_char(1'b0));
      if ($urandom_range(0, 9) < 8) begin
        chars.push_back(CH_DOT);
        repeat ($urandom_range(0, 5)) chars.push_back(pick_name_char(1'b1));
      end
      // early end by NUL somewhere in the name
      if (chars.size() != 0 && $urandom_range(0, 15) == 0)
        chars[$urandom_range(0, chars.size() - 1)] = CH_NUL;
    end
    if (chars.size() == 0)
      chars.push_back(CH_NUL);  // empty name closed by a flagged NUL
    foreach (chars[i])
      push_char(chars[i], i == chars.size() - 1);
  endtask

  // Holds the test sequence until every queued char is taken and every result is in;
  // checked on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do
      @(negedge clk);
    while (name_chars_q.size() != 0 || in_tvalid || fcb_expected_q.size() != 0);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: one char per transaction, random gaps between them
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (tx_gap > 0) begin
        in_tvalid <= 1'b0;
        tx_gap    <= tx_gap - 1;
      end else if (name_chars_q.size() != 0) begin
        name_char_t nc;
        nc = name_chars_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nc.ch;
        in_tlast  <= nc.last;
        tx_count  <= tx_count + 1;
        // every hundred chars decide whether the next stretch runs back to back
        if (tx_count % 100 == 0)
          tx_burst <= ($urandom_range(0, 3) == 0);
        tx_gap <= pick_gap(tx_burst);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls on the result channel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if (out_tvalid && out_tready) begin
        rx_count <= rx_count + 1;
        if (rx_count % 20 == 0)
          rx_burst <= ($urandom_range(0, 3) == 0);
        rx_hold <= pick_gap(rx_burst);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then predict from the accepted char
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    fcb_entry_t want;
    fcb_entry_t made;
    if (!rst_n) begin
      clear_name_state();
    end else begin
      if (out_tvalid && out_tready) begin
        if (fcb_expected_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[63:0], 64'h0);
        end else begin
          want = fcb_expected_q.pop_front();
          if (out_tdata[63:0] !== want.base)
            report_mismatch("base_field", out_tdata[63:0], want.base);
          if (out_tdata[87:64] !== want.ext)
            report_mismatch("ext_field", 64'(out_tdata[87:64]), 64'(want.ext));
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_char(in_tdata);
        if (in_tlast) begin
          close_name(made);
          fcb_expected_q.push_back(made);
        end
      end
    end
  end

  // Watchdog: too long without any transaction means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("fcb_8_3_name_formatter verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed names
    push_text(".");               // single dot form
    push_text("..");              // double dot form
    push_text("*.*");             // star fill in base and extension
    push_text("ABCDEFGHI.a.cd");  // base overflow skipped, dot kept in ext, ext overflow
    push_char(8'hFF, 1'b0);       // top-bit char, then early end by NUL
    push_char(CH_NUL, 1'b0);
    push_char("B", 1'b1);
    push_char(CH_NUL, 1'b1);      // flagged NUL alone gives an all-blank entry

    // Let everything settle once before the random traffic
    wait_drained();

    while (chars_queued < CHAR_TARGET) begin
      queue_random_name();
      if (chars_queued >= CHAR_TARGET / 2 && chars_queued < CHAR_TARGET / 2 + 13)
        wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("fcb_8_3_name_formatter verification clean");
    else
      $display("fcb_8_3_name_formatter verification failed");
    $finish;
  end

endmodule
